[hw/rtl/vector_to_pitch_yaw_unit_defines.svh]
// Assertion helpers shared by the aim-angle RTL.
`ifndef VECTOR_TO_PITCH_YAW_UNIT_DEFINES_SVH
`define VECTOR_TO_PITCH_YAW_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define V2PY_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define V2PY_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/v2py_pkg.sv]
`timescale 1ns / 1ps
package v2py_pkg;

    localparam int DW        = 44;  // CORDIC datapath, signed
    localparam int AW        = 26;  // angle accumulator, 2^-15 degree
    localparam int TABLE_LEN = 24;
    localparam int KW        = 20;

    localparam logic [KW-1:0]        INV_GAIN    = 20'd636751;
    localparam logic signed [AW-1:0] DEG180      = 26'sd5898240;
    localparam int                   PITCH_LIMIT = 11520;
    localparam int                   YAW_LIMIT   = 23040;

    // atan(2^-i) in 2^-15 degree
    localparam logic signed [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
        26'sd1474560, 26'sd870484, 26'sd459940, 26'sd233473, 26'sd117189, 26'sd58652,
        26'sd29333, 26'sd14667, 26'sd7334, 26'sd3667, 26'sd1833, 26'sd917,
        26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29, 26'sd14,
        26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0, 26'sd0
    };

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
    } t_target;

    typedef struct packed {
        logic signed [14:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               zero_vector;
    } t_result;

    // side data carried along the yaw pass
    typedef struct packed {
        logic               zero;
        logic               no_horiz;
        logic signed [DW-1:0] z;
    } t_yaw_side;

    // side data carried through the gain multiply
    typedef struct packed {
        logic               zero;
        logic               no_horiz;
        logic signed [AW-1:0] yaw;
        logic signed [DW-1:0] z;
    } t_gain_side;

    // side data carried along the pitch pass
    typedef struct packed {
        logic               zero;
        logic               no_horiz;
        logic signed [AW-1:0] yaw;
    } t_pitch_side;

endpackage

[hw/rtl/v2py_cordic.sv]
`timescale 1ns / 1ps
`include "vector_to_pitch_yaw_unit_defines.svh"
module v2py_cordic import v2py_pkg::*; #(
    parameter int STAGES = 16,
    parameter int SB_W   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [DW-1:0] i_x,
    input  logic signed [DW-1:0] i_y,
    input  logic signed [AW-1:0] i_acc,
    input  logic [SB_W-1:0]      i_side,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [DW-1:0] o_x,
    output logic signed [AW-1:0] o_acc,
    output logic [SB_W-1:0]      o_side
);

    logic signed [DW-1:0] x_c   [0:STAGES];
    logic signed [DW-1:0] y_c   [0:STAGES];
    logic signed [AW-1:0] acc_c [0:STAGES];
    logic [SB_W-1:0]      sb_c  [0:STAGES];
    logic                 vld_c [0:STAGES];
    logic                 st_c  [0:STAGES];

    assign x_c[0]      = i_x;
    assign y_c[0]      = i_y;
    assign acc_c[0]    = i_acc;
    assign sb_c[0]     = i_side;
    assign vld_c[0]    = i_valid;
    assign st_c[STAGES] = i_stall;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic signed [DW-1:0] r_x, r_y, n_x, n_y;
        logic signed [AW-1:0] r_acc, n_acc;
        logic [SB_W-1:0]      r_sb;
        logic                 r_vld;

        // rotate toward the x axis by atan(2^-k)
        always_comb begin
            if (!y_c[k][DW-1]) begin
                n_x   = x_c[k] + (y_c[k] >>> k);
                n_y   = y_c[k] - (x_c[k] >>> k);
                n_acc = acc_c[k] + ATAN_TAB[k];
            end else begin
                n_x   = x_c[k] - (y_c[k] >>> k);
                n_y   = y_c[k] + (x_c[k] >>> k);
                n_acc = acc_c[k] - ATAN_TAB[k];
            end
        end

        assign st_c[k] = r_vld & st_c[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (!st_c[k]) begin
                r_vld <= vld_c[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!st_c[k]) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_acc <= n_acc;
                r_sb  <= sb_c[k];
            end
        end

        assign x_c[k+1]   = r_x;
        assign y_c[k+1]   = r_y;
        assign acc_c[k+1] = r_acc;
        assign sb_c[k+1]  = r_sb;
        assign vld_c[k+1] = r_vld;
    end

    assign o_stall = st_c[0];
    assign o_valid = vld_c[STAGES];
    assign o_x     = x_c[STAGES];
    assign o_acc   = acc_c[STAGES];
    assign o_side  = sb_c[STAGES];

    // x starts non-negative and only grows in vectoring mode
    `V2PY_ASSERT_NOW(a_x_nonneg, o_valid, !o_x[DW-1], "cordic x went negative")
    // input stall only when the first stage holds an item
    `V2PY_ASSERT_NOW(a_stall_full, o_stall, vld_c[1], "input stalled with empty first stage")
    // a stalled result stays offered
    `V2PY_ASSERT_NEXT(a_hold_out, o_valid && i_stall, o_valid, "stalled item dropped")

endmodule

[hw/rtl/v2py_gain.sv]
`timescale 1ns / 1ps
module v2py_gain import v2py_pkg::*; #(
    parameter int SB_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [DW-1:0] i_x,
    input  logic [SB_W-1:0]      i_side,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [DW-1:0] o_r,
    output logic [SB_W-1:0]      o_side
);

    localparam int LO_W = DW / 2;
    localparam int HI_W = DW - LO_W;
    localparam int PW   = DW + KW + 2;

    logic [LO_W+KW-1:0] r_lo;
    logic [HI_W+KW-1:0] r_hi;
    logic [SB_W-1:0]    r_sb1, r_sb2;
    logic signed [DW-1:0] r_r;
    logic               r_vld1, r_vld2;
    logic               st1, st2;
    logic [PW-1:0]      sum;

    assign st2     = r_vld2 & i_stall;
    assign st1     = r_vld1 & st2;
    assign o_stall = st1;

    // x is non-negative here: split into two unsigned partial products
    always_ff @(posedge i_clk) begin
        if (!st1) begin
            r_lo  <= i_x[LO_W-1:0] * INV_GAIN;
            r_hi  <= i_x[DW-1:LO_W] * INV_GAIN;
            r_sb1 <= i_side;
        end
    end

    // combine, round half up, drop 20 fraction bits
    assign sum = {{(PW-HI_W-KW-LO_W){1'b0}}, r_hi, {LO_W{1'b0}}}
               + {{(PW-LO_W-KW){1'b0}}, r_lo}
               + PW'(1 << (KW - 1));

    always_ff @(posedge i_clk) begin
        if (!st2) begin
            r_r   <= $signed(sum[KW +: DW]);
            r_sb2 <= r_sb1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (!st1) begin
                r_vld1 <= i_valid;
            end
            if (!st2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    assign o_valid = r_vld2;
    assign o_r     = r_r;
    assign o_side  = r_sb2;

endmodule

[hw/rtl/vector_to_pitch_yaw_unit.sv]
// N = min(CORDIC_STAGES, 24) rotations per CORDIC pass, each in its own register.
// Throughput: one item per cycle while no stall holds the pipeline.
// Stalls back up stage by stage, so empty stages still fill while the output waits.
// Reset (synchronous, active low) clears all valid bits and zero_tolerance to 0.
`timescale 1ns / 1ps
`include "vector_to_pitch_yaw_unit_defines.svh"
module vector_to_pitch_yaw_unit import v2py_pkg::*; #(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_target    i_target,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result
);

    localparam int W     = COORD_WIDTH;
    localparam int GUARD = 40 - W;
    localparam int NSTG  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int YW    = $bits(t_yaw_side);
    localparam int GW    = $bits(t_gain_side);
    localparam int PW    = $bits(t_pitch_side);
    localparam int QW    = AW - 7;   // rounded angle width

    // tolerance register
    logic [7:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 8'd0;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    // ---------------- entry stage: zero check, guard shift, half-plane fold
    logic [31:0]          raw_x, raw_y, raw_z;
    logic signed [W-1:0]  cx, cy, cz;
    logic [W:0]           mx, my, mz;
    logic signed [DW-1:0] sx, sy, sz;
    logic                 zero, neg;
    logic signed [DW-1:0] n_px, n_py;
    logic signed [AW-1:0] n_pbase;
    t_yaw_side            n_pside;

    // only the low COORD_WIDTH bits of each field are the coordinate
    assign raw_x = {16'd0, i_target.target_x};
    assign raw_y = {16'd0, i_target.target_y};
    assign raw_z = {16'd0, i_target.target_z};
    assign cx    = $signed(raw_x[W-1:0]);
    assign cy    = $signed(raw_y[W-1:0]);
    assign cz    = $signed(raw_z[W-1:0]);

    assign mx = cx[W-1] ? ({1'b0, ~cx} + (W+1)'(1)) : {1'b0, cx};
    assign my = cy[W-1] ? ({1'b0, ~cy} + (W+1)'(1)) : {1'b0, cy};
    assign mz = cz[W-1] ? ({1'b0, ~cz} + (W+1)'(1)) : {1'b0, cz};

    assign zero = (mx <= {{(W-7){1'b0}}, r_tol}) && (my <= {{(W-7){1'b0}}, r_tol})
               && (mz <= {{(W-7){1'b0}}, r_tol});

    assign sx  = {{(DW-W){cx[W-1]}}, cx} <<< GUARD;
    assign sy  = {{(DW-W){cy[W-1]}}, cy} <<< GUARD;
    assign sz  = {{(DW-W){cz[W-1]}}, cz} <<< GUARD;
    assign neg = cx[W-1];

    // fold the left half-plane onto the right, starting yaw from +-180
    always_comb begin
        if (neg) begin
            n_px    = -sx;
            n_py    = -sy;
            n_pbase = cy[W-1] ? -DEG180 : DEG180;
        end else begin
            n_px    = sx;
            n_py    = sy;
            n_pbase = '0;
        end
        n_pside.zero     = zero;
        n_pside.no_horiz = (cx == '0) && (cy == '0);
        n_pside.z        = sz;
    end

    logic signed [DW-1:0] r_px, r_py;
    logic signed [AW-1:0] r_pbase;
    t_yaw_side            r_pside;
    logic                 r_pvld;
    logic                 yaw_stall, st_prep;

    assign st_prep = r_pvld & yaw_stall;
    assign o_stall = st_prep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (!st_prep) begin
            r_pvld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st_prep) begin
            r_px    <= n_px;
            r_py    <= n_py;
            r_pbase <= n_pbase;
            r_pside <= n_pside;
        end
    end

    // ---------------- yaw pass on (x, y)
    logic                 yaw_vld, gain_stall;
    logic signed [DW-1:0] yaw_x;
    logic signed [AW-1:0] yaw_acc;
    logic [YW-1:0]        yaw_sb;
    t_yaw_side            yaw_side;
    t_gain_side           gain_in_side;

    v2py_cordic #(.STAGES(NSTG), .SB_W(YW)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pvld),
        .o_stall (yaw_stall),
        .i_x     (r_px),
        .i_y     (r_py),
        .i_acc   (r_pbase),
        .i_side  (r_pside),
        .o_valid (yaw_vld),
        .i_stall (gain_stall),
        .o_x     (yaw_x),
        .o_acc   (yaw_acc),
        .o_side  (yaw_sb)
    );

    assign yaw_side              = t_yaw_side'(yaw_sb);
    assign gain_in_side.zero     = yaw_side.zero;
    assign gain_in_side.no_horiz = yaw_side.no_horiz;
    assign gain_in_side.yaw      = yaw_acc;
    assign gain_in_side.z        = yaw_side.z;

    // ---------------- inverse-gain scaling of the horizontal length
    logic                 gain_vld, pitch_stall;
    logic signed [DW-1:0] gain_r;
    logic [GW-1:0]        gain_sb;
    t_gain_side           gain_side;
    t_pitch_side          pitch_in_side;

    v2py_gain #(.SB_W(GW)) u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (yaw_vld),
        .o_stall (gain_stall),
        .i_x     (yaw_x),
        .i_side  (gain_in_side),
        .o_valid (gain_vld),
        .i_stall (pitch_stall),
        .o_r     (gain_r),
        .o_side  (gain_sb)
    );

    assign gain_side              = t_gain_side'(gain_sb);
    assign pitch_in_side.zero     = gain_side.zero;
    assign pitch_in_side.no_horiz = gain_side.no_horiz;
    assign pitch_in_side.yaw      = gain_side.yaw;

    // ---------------- pitch pass on (length, z)
    logic                 pitch_vld, st_out;
    logic signed [DW-1:0] pitch_x;
    logic signed [AW-1:0] pitch_acc;
    logic [PW-1:0]        pitch_sb;
    t_pitch_side          pitch_side;

    v2py_cordic #(.STAGES(NSTG), .SB_W(PW)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (gain_vld),
        .o_stall (pitch_stall),
        .i_x     (gain_r),
        .i_y     (gain_side.z),
        .i_acc   ('0),
        .i_side  (pitch_in_side),
        .o_valid (pitch_vld),
        .i_stall (st_out),
        .o_x     (pitch_x),
        .o_acc   (pitch_acc),
        .o_side  (pitch_sb)
    );

    assign pitch_side = t_pitch_side'(pitch_sb);

    // ---------------- output stage: round half up to 1/128 degree, clamp
    logic signed [AW:0]   p_rnd, y_rnd;
    logic signed [QW-1:0] p_q, y_q, p_c, y_c;
    t_result              n_out, r_out;
    logic                 r_ovld;

    assign p_rnd = {pitch_acc[AW-1], pitch_acc} + (AW+1)'(128);
    assign y_rnd = {pitch_side.yaw[AW-1], pitch_side.yaw} + (AW+1)'(128);
    assign p_q   = p_rnd[AW:8];
    assign y_q   = y_rnd[AW:8];

    always_comb begin
        if (p_q > $signed(QW'(PITCH_LIMIT))) begin
            p_c = QW'(PITCH_LIMIT);
        end else if (p_q < -$signed(QW'(PITCH_LIMIT))) begin
            p_c = -$signed(QW'(PITCH_LIMIT));
        end else begin
            p_c = p_q;
        end
        if (y_q > $signed(QW'(YAW_LIMIT))) begin
            y_c = QW'(YAW_LIMIT);
        end else if (y_q < -$signed(QW'(YAW_LIMIT))) begin
            y_c = -$signed(QW'(YAW_LIMIT));
        end else begin
            y_c = y_q;
        end
        // a zero vector forces both angles; no horizontal part forces yaw
        if (pitch_side.zero) begin
            n_out.pitch_angle = '0;
            n_out.yaw_angle   = '0;
            n_out.zero_vector = 1'b1;
        end else begin
            n_out.pitch_angle = p_c[14:0];
            n_out.yaw_angle   = pitch_side.no_horiz ? 16'sd0 : y_c[15:0];
            n_out.zero_vector = 1'b0;
        end
    end

    assign st_out = r_ovld & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (!st_out) begin
            r_ovld <= pitch_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_ovld;
    assign o_result = r_out;

    `V2PY_ASSERT_NOW(a_zero_angles, o_valid && o_result.zero_vector,
        o_result.pitch_angle == 15'sd0 && o_result.yaw_angle == 16'sd0,
        "zero vector with nonzero angle")
    `V2PY_ASSERT_NOW(a_pitch_range, o_valid,
        o_result.pitch_angle <= 15'sd11520 && o_result.pitch_angle >= -15'sd11520,
        "pitch out of range")
    `V2PY_ASSERT_NOW(a_yaw_range, o_valid,
        o_result.yaw_angle <= 16'sd23040 && o_result.yaw_angle >= -16'sd23040,
        "yaw out of range")
    `V2PY_ASSERT_NEXT(a_out_load, pitch_vld && !st_out, o_valid,
        "finished item not captured at output")

endmodule
